FILE: sv/uniform_mod_q_rejection_sampler_unit_defines.svh
// Assertion macros used by the rejection sampler queue.
`ifndef UNIFORM_MOD_Q_REJECTION_SAMPLER_UNIT_DEFINES_SVH
`define UNIFORM_MOD_Q_REJECTION_SAMPLER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define RQS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

FILE: sv/rqs_pkg.sv
// Types and constants shared by the rejection sampler modules.
`default_nettype none
package rqs_pkg;

    localparam int MAX_COEFFS  = 256;
    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W   = 8;
    localparam int COEF_W   = 12;
    localparam int IDX_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int QMOD_W   = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [QMOD_W-1:0]    Q_MOD_RESET  = 13'd3329;
    localparam logic [COUNT_W-1:0]   TARGET_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_Q_MODULUS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 1'b1;

    // One result item.
    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_coef_item;

    // Results written by the front into the queue in one cycle.
    typedef struct packed {
        logic [1:0]  n;
        t_coef_item  item0;
        t_coef_item  item1;
    } t_push;

    // Queue status seen by front and back.
    typedef struct packed {
        logic empty;
        logic room2;
    } t_q_status;

endpackage
`default_nettype wire

FILE: sv/rqs_front.sv
// Byte grouping, candidate test, coefficient counting and the configuration registers.
`default_nettype none
module rqs_front #(
    parameter int P_MAX_COEFFS = rqs_pkg::MAX_COEFFS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [rqs_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic                            i_start_new,
    input  wire logic                            i_cfg_valid,
    input  wire logic [rqs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rqs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire rqs_pkg::t_q_status              i_q_status,
    output rqs_pkg::t_push                       o_push
);
    import rqs_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    localparam logic [10:0] MAXC = 11'(P_MAX_COEFFS);

    logic [QMOD_W-1:0]  r_q_mod;
    logic [COUNT_W-1:0] r_target;
    logic [BYTE_W-1:0]  r_first,  n_first;
    logic [BYTE_W-1:0]  r_second, n_second;
    t_phase             r_phase,  n_phase;
    logic [COUNT_W-1:0] r_count,  n_count;

    logic               accept;
    t_phase             phase_eff;
    logic [COUNT_W-1:0] cnt_eff, cnt_p1, cnt1, cnt1_p1, tgt_eff;
    logic               full, ok0, ok1, take0, take1;
    logic [COEF_W-1:0]  c0, c1;
    t_coef_item         e0, e1;

    assign o_stall = !i_q_status.room2;
    assign accept  = i_valid && !o_stall;

    assign phase_eff = i_start_new ? PH_FIRST : r_phase;
    assign cnt_eff   = i_start_new ? '0 : r_count;
    assign tgt_eff   = ({2'b00, r_target} > MAXC) ? MAXC[COUNT_W-1:0] : r_target;
    assign full      = cnt_eff >= tgt_eff;

    assign c0 = {r_second[3:0], r_first};
    assign c1 = {i_data_byte, r_second[7:4]};

    assign ok0     = {1'b0, c0} < r_q_mod;
    assign ok1     = {1'b0, c1} < r_q_mod;
    assign cnt_p1  = cnt_eff + 1'b1;
    assign cnt1    = ok0 ? cnt_p1 : cnt_eff;
    assign cnt1_p1 = cnt1 + 1'b1;
    assign take0   = ok0;
    assign take1   = ok1 && (cnt1 < tgt_eff);

    assign e0 = '{coef: c0, idx: cnt_eff[IDX_W-1:0], last: cnt_p1 == tgt_eff};
    assign e1 = '{coef: c1, idx: cnt1[IDX_W-1:0],    last: cnt1_p1 == tgt_eff};

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_phase  = r_phase;
        n_count  = r_count;
        o_push   = '{n: 2'd0, item0: e0, item1: e1};
        if (accept) begin
            n_phase = phase_eff;
            n_count = cnt_eff;
            if (!full) begin
                unique case (phase_eff)
                    PH_FIRST: begin
                        n_first = i_data_byte;
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_second = i_data_byte;
                        n_phase  = PH_THIRD;
                    end
                    default: begin
                        // third byte: offer both candidates in order
                        n_phase  = PH_FIRST;
                        n_count  = cnt1 + COUNT_W'(take1);
                        o_push.n = 2'(take0) + 2'(take1);
                        if (!take0) begin
                            o_push.item0 = e1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_mod  <= Q_MOD_RESET;
            r_target <= TARGET_RESET;
            r_first  <= '0;
            r_second <= '0;
            r_phase  <= PH_FIRST;
            r_count  <= '0;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
            r_phase  <= n_phase;
            r_count  <= n_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_Q_MODULUS:    r_q_mod  <= i_cfg_data;
                    CFG_TARGET_COUNT: r_target <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/rqs_queue.sv
// Result queue between front and back, up to two writes and one read a cycle.
`default_nettype none
module rqs_queue #(
    parameter int P_DEPTH = rqs_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rqs_pkg::t_push       i_push,
    input  wire logic                 i_pop,
    output rqs_pkg::t_coef_item       o_head,
    output rqs_pkg::t_q_status        o_status
);
    import rqs_pkg::*;
    `include "uniform_mod_q_rejection_sampler_unit_defines.svh"

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_coef_item       r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd, wr_p1;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(P_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_p1 = ptr_inc(r_wr);
    assign o_head = r_mem[r_rd];
    assign o_status.empty = r_count == '0;
    assign o_status.room2 = r_count <= CNT_W'(P_DEPTH - 2);

    always_comb begin
        n_wr = r_wr;
        case (i_push.n)
            2'd1:    n_wr = wr_p1;
            2'd2:    n_wr = ptr_inc(wr_p1);
            default: n_wr = r_wr;
        endcase
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_push.n) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_p1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `RQS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(P_DEPTH), "queue count past depth")
    `RQS_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, {1'b0, r_count} + (CNT_W+1)'(i_push.n) > (CNT_W+1)'(P_DEPTH), "queue written without room")
    `RQS_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == '0), "queue read while empty")

endmodule
`default_nettype wire

FILE: sv/rqs_back.sv
// Output register that drains the result queue onto the output channel.
`default_nettype none
module rqs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rqs_pkg::t_coef_item  i_head,
    input  wire rqs_pkg::t_q_status   i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rqs_pkg::t_coef_item       o_item
);
    import rqs_pkg::*;

    logic       r_valid;
    t_coef_item r_item;

    // Load when the register is free or its item leaves this cycle.
    assign o_pop   = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

endmodule
`default_nettype wire

FILE: sv/uniform_mod_q_rejection_sampler_unit.sv
// Top level of the uniform mod-q rejection sampler.
// Throughput: one byte item per cycle while o_stall is low; every third byte writes up to two results.
// A result is written into the queue as its third byte is accepted, then moves into the output register.
// The result queue drains one result per cycle through the output register while i_stall is low.
// Input stall rises only while the queue has fewer than two free entries.
// Reset (synchronous, active low): phase and count clear, q_modulus 3329, target 256.
`default_nettype none
module uniform_mod_q_rejection_sampler_unit #(
    parameter int P_QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // byte items in
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [rqs_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic                            i_start_new,
    // result items out
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [rqs_pkg::COEF_W-1:0]           o_coefficient,
    output logic [rqs_pkg::IDX_W-1:0]            o_coeff_index,
    output logic                                 o_last_of_poly,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rqs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rqs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rqs_pkg::*;

    t_push      push;
    t_q_status  q_status;
    t_coef_item head, out_item;
    logic       pop;

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Front: group bytes, test candidates, count and tag accepted ones.
    rqs_front #(
        .P_MAX_COEFFS (MAX_COEFFS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_start_new (i_start_new),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push)
    );

    // Queue: hold results so the front waits on a stalled output only once the queue lacks room for two.
    rqs_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Back: advance one result per cycle into the output register while the output is not stalled.
    rqs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (out_item)
    );

    assign o_coefficient  = out_item.coef;
    assign o_coeff_index  = out_item.idx;
    assign o_last_of_poly = out_item.last;

endmodule
`default_nettype wire
